// ----- design/assert_macros.svh -----
// Assertion macros shared by the outline builder's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside of reset.
`define VRCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define VRCC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define VRCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/vrcc_pkg.sv -----
// Shared constants and codes of the clipped cell outline builder.
package vrcc_pkg;

  // Distance test: each axis offset must stay below 2**DIST_BITS.
  localparam int unsigned DIST_BITS = 16;
  localparam int unsigned SQ_BITS   = 2 * DIST_BITS;
  localparam int unsigned NEAR_BITS = 16;

  // One item produces at most four vertices.
  localparam int unsigned MAX_VERTS = 4;
  localparam int unsigned VIDX_W    = 2;
  localparam int unsigned CNT_W     = 3;

  // Depth of the record queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Bit positions of the rectangle side flags.
  localparam int unsigned SIDE_L = 0;
  localparam int unsigned SIDE_R = 1;
  localparam int unsigned SIDE_T = 2;
  localparam int unsigned SIDE_B = 3;
  localparam int unsigned SIDE_W = 4;

  // Item modes.
  localparam logic MODE_EDGE  = 1'b0;
  localparam logic MODE_CLOSE = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT   = 3'd0,
    CFG_RIGHT  = 3'd1,
    CFG_TOP    = 3'd2,
    CFG_BOTTOM = 3'd3,
    CFG_NEAR   = 3'd4
  } cfg_idx_e;

  localparam logic [NEAR_BITS-1:0] NEAR_RESET = 16'd2;

endpackage

// ----- design/vrcc_queue.sv -----
// Small register queue that carries vertex records from the front to the back part.
`include "assert_macros.svh"

module vrcc_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  // DEPTH is a power of two, so the pointers wrap by truncation.
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Record storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `VRCC_ASSERT_IMP(a_queue_no_overflow, push_i, !full_o, "push into a full queue")
  `VRCC_ASSERT_IMP(a_queue_no_underflow, pop_i, !empty_o, "pop from an empty queue")
  `VRCC_ASSERT(a_queue_count_range, count_q <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

// ----- design/vrcc_front.sv -----
// Front part: takes items, runs the coincidence and side tests, builds vertex records.
`include "assert_macros.svh"

module vrcc_front #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned CFG_W      = 24,
  parameter int unsigned REC_W      = 195
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vrcc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]                 cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             mode_i,
  input  logic                             visible_i,
  input  logic signed [COORD_BITS-1:0]     end_a_x_i,
  input  logic signed [COORD_BITS-1:0]     end_a_y_i,
  input  logic signed [COORD_BITS-1:0]     end_b_x_i,
  input  logic signed [COORD_BITS-1:0]     end_b_y_i,
  output logic                             push_o,
  output logic [REC_W-1:0]                 rec_o,
  input  logic                             full_i
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned DB   = vrcc_pkg::DIST_BITS;
  localparam int unsigned SQW  = vrcc_pkg::SQ_BITS;
  localparam int unsigned NB   = vrcc_pkg::NEAR_BITS;
  localparam int unsigned NV   = vrcc_pkg::MAX_VERTS;
  localparam int unsigned CW   = vrcc_pkg::CNT_W;
  localparam int unsigned IW   = vrcc_pkg::VIDX_W;
  localparam int unsigned SW   = vrcc_pkg::SIDE_W;
  // Offsets need C+1 bits and at least DB+1 so the range test has an upper part.
  localparam int unsigned DW   = (C + 1 > DB + 1) ? C + 1 : DB + 1;
  // Sums of two offsets for the nearer corner pair.
  localparam int unsigned EW   = C + 2;

  typedef enum logic [1:0] {
    PH_SQ1,
    PH_SQ2,
    PH_FIN
  } phase_e;

  // Control state, configuration and polygon state.
  phase_e               phase_q;
  logic                 item_valid_q;
  logic                 started_q;
  logic signed [C-1:0]  fa_x_q, fa_y_q, fb_x_q, fb_y_q;
  logic signed [C-1:0]  prev_x_q, prev_y_q;
  logic signed [C-1:0]  bnd_l_q, bnd_r_q, bnd_t_q, bnd_b_q;
  logic [NB-1:0]        near_q;

  // Held item.
  logic                 it_mode_q, it_vis_q;
  logic signed [C-1:0]  it_ax_q, it_ay_q, it_bx_q, it_by_q;

  // Datapath registers between phases.
  logic [SQW-1:0]       sq_x_q, sq_y_q;
  logic                 big_q;
  logic                 coin1_q;
  logic [SW-1:0]        rs_q, ns_q;
  logic                 upper_q, lefter_q, diff_q;

  // Join points: on a close item the first edge stands in for the item.
  logic signed [C-1:0]  ja_x, ja_y, jb_x, jb_y;
  always_comb begin
    ja_x = (it_mode_q == vrcc_pkg::MODE_CLOSE) ? fa_x_q : it_ax_q;
    ja_y = (it_mode_q == vrcc_pkg::MODE_CLOSE) ? fa_y_q : it_ay_q;
    jb_x = (it_mode_q == vrcc_pkg::MODE_CLOSE) ? fb_x_q : it_bx_q;
    jb_y = (it_mode_q == vrcc_pkg::MODE_CLOSE) ? fb_y_q : it_by_q;
  end

  // Shared distance unit: last vertex against end A first, then first end A against end B.
  logic signed [C-1:0]  op_px, op_py, op_qx, op_qy;
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        abs_x, abs_y;
  logic                 big_d;
  logic [SQW-1:0]       sq_x_d, sq_y_d;
  always_comb begin
    if (phase_q == PH_SQ1) begin
      op_px = prev_x_q;
      op_py = prev_y_q;
      op_qx = ja_x;
      op_qy = ja_y;
    end else begin
      op_px = fa_x_q;
      op_py = fa_y_q;
      op_qx = jb_x;
      op_qy = jb_y;
    end
    dx     = DW'(op_px) - DW'(op_qx);
    dy     = DW'(op_py) - DW'(op_qy);
    abs_x  = dx[DW-1] ? DW'(-dx) : DW'(dx);
    abs_y  = dy[DW-1] ? DW'(-dy) : DW'(dy);
    big_d  = (|abs_x[DW-1:DB]) || (|abs_y[DW-1:DB]);
    sq_x_d = SQW'(abs_x[DB-1:0]) * SQW'(abs_x[DB-1:0]);
    sq_y_d = SQW'(abs_y[DB-1:0]) * SQW'(abs_y[DB-1:0]);
  end

  // Coincidence from the registered squares.
  logic coin_now;
  assign coin_now = !big_q &&
                    ((SQW + 1)'(sq_x_q) + (SQW + 1)'(sq_y_q) < (SQW + 1)'(near_q));

  // Side flags and nearer corner pair for the join from the last vertex to end A.
  logic [SW-1:0]        rs_d, ns_d;
  logic signed [EW-1:0] up_sum, up_span, lf_sum, lf_span;
  always_comb begin
    rs_d = '0;
    ns_d = '0;
    rs_d[vrcc_pkg::SIDE_L] = (prev_x_q == bnd_l_q);
    rs_d[vrcc_pkg::SIDE_R] = (prev_x_q == bnd_r_q);
    rs_d[vrcc_pkg::SIDE_T] = (prev_y_q == bnd_t_q);
    rs_d[vrcc_pkg::SIDE_B] = (prev_y_q == bnd_b_q);
    ns_d[vrcc_pkg::SIDE_L] = (ja_x == bnd_l_q);
    ns_d[vrcc_pkg::SIDE_R] = (ja_x == bnd_r_q);
    ns_d[vrcc_pkg::SIDE_T] = (ja_y == bnd_t_q);
    ns_d[vrcc_pkg::SIDE_B] = (ja_y == bnd_b_q);
    up_sum  = (EW'(prev_y_q) - EW'(bnd_t_q)) + (EW'(ja_y) - EW'(bnd_t_q));
    up_span = EW'(bnd_b_q) - EW'(bnd_t_q);
    lf_sum  = (EW'(prev_x_q) - EW'(bnd_l_q)) + (EW'(ja_x) - EW'(bnd_l_q));
    lf_span = EW'(bnd_r_q) - EW'(bnd_l_q);
  end

  // Rectangle corners between the last vertex and end A.
  logic signed [C-1:0] py, px;
  logic signed [C-1:0] c0_x, c0_y, c1_x, c1_y;
  logic [CW-1:0]       cn;
  always_comb begin
    py   = upper_q ? bnd_t_q : bnd_b_q;
    px   = lefter_q ? bnd_l_q : bnd_r_q;
    c0_x = bnd_l_q;
    c0_y = bnd_t_q;
    c1_x = bnd_l_q;
    c1_y = bnd_t_q;
    cn   = '0;
    priority if (rs_q[vrcc_pkg::SIDE_R]) begin
      priority if (ns_q[vrcc_pkg::SIDE_B]) begin
        c0_x = bnd_r_q; c0_y = bnd_b_q; cn = CW'(1);
      end else if (ns_q[vrcc_pkg::SIDE_T]) begin
        c0_x = bnd_r_q; c0_y = bnd_t_q; cn = CW'(1);
      end else if (ns_q[vrcc_pkg::SIDE_L]) begin
        c0_x = bnd_r_q; c0_y = py; c1_x = bnd_l_q; c1_y = py; cn = CW'(2);
      end else begin
        cn = '0;
      end
    end else if (rs_q[vrcc_pkg::SIDE_L]) begin
      priority if (ns_q[vrcc_pkg::SIDE_B]) begin
        c0_x = bnd_l_q; c0_y = bnd_b_q; cn = CW'(1);
      end else if (ns_q[vrcc_pkg::SIDE_T]) begin
        c0_x = bnd_l_q; c0_y = bnd_t_q; cn = CW'(1);
      end else if (ns_q[vrcc_pkg::SIDE_R]) begin
        c0_x = bnd_l_q; c0_y = py; c1_x = bnd_r_q; c1_y = py; cn = CW'(2);
      end else begin
        cn = '0;
      end
    end else if (rs_q[vrcc_pkg::SIDE_T]) begin
      priority if (ns_q[vrcc_pkg::SIDE_R]) begin
        c0_x = bnd_r_q; c0_y = bnd_t_q; cn = CW'(1);
      end else if (ns_q[vrcc_pkg::SIDE_L]) begin
        c0_x = bnd_l_q; c0_y = bnd_t_q; cn = CW'(1);
      end else if (ns_q[vrcc_pkg::SIDE_B]) begin
        c0_x = px; c0_y = bnd_t_q; c1_x = px; c1_y = bnd_b_q; cn = CW'(2);
      end else begin
        cn = '0;
      end
    end else if (rs_q[vrcc_pkg::SIDE_B]) begin
      priority if (ns_q[vrcc_pkg::SIDE_R]) begin
        c0_x = bnd_r_q; c0_y = bnd_b_q; cn = CW'(1);
      end else if (ns_q[vrcc_pkg::SIDE_L]) begin
        c0_x = bnd_l_q; c0_y = bnd_b_q; cn = CW'(1);
      end else if (ns_q[vrcc_pkg::SIDE_T]) begin
        c0_x = px; c0_y = bnd_b_q; c1_x = px; c1_y = bnd_t_q; cn = CW'(2);
      end else begin
        cn = '0;
      end
    end else begin
      // The last vertex lies on no side, so no corner goes in.
      cn = '0;
    end
  end

  // Vertex list of the held item, assembled in emit order.
  logic signed [C-1:0] vx [NV];
  logic signed [C-1:0] vy [NV];
  logic [CW-1:0]       n;
  logic [CW-1:0]       n_last;
  always_comb begin
    for (int k = 0; k < NV; k++) begin
      vx[k] = '0;
      vy[k] = '0;
    end
    n = '0;
    if (it_mode_q == vrcc_pkg::MODE_CLOSE) begin
      if (!coin1_q) begin
        if (diff_q) begin
          vx[0] = c0_x; vy[0] = c0_y;
          vx[1] = c1_x; vy[1] = c1_y;
          n = cn;
        end
      end else if (!coin_now) begin
        vx[0] = jb_x; vy[0] = jb_y;
        n = CW'(1);
      end
    end else if (!started_q) begin
      vx[0] = ja_x; vy[0] = ja_y;
      vx[1] = jb_x; vy[1] = jb_y;
      n = CW'(2);
    end else begin
      if (!coin1_q) begin
        if (diff_q) begin
          vx[0] = c0_x; vy[0] = c0_y;
          vx[1] = c1_x; vy[1] = c1_y;
          n = cn;
        end
        vx[n[IW-1:0]] = ja_x;
        vy[n[IW-1:0]] = ja_y;
        n = n + 1'b1;
      end
      if (!coin_now) begin
        vx[n[IW-1:0]] = jb_x;
        vy[n[IW-1:0]] = jb_y;
        n = n + 1'b1;
      end
    end
    n_last = n - 1'b1;
  end

  // Record packing: count in the low bits, then x and y of each vertex.
  always_comb begin
    rec_o = '0;
    rec_o[CW-1:0] = n;
    for (int k = 0; k < NV; k++) begin
      rec_o[CW + 2*C*k +: C]     = vx[k];
      rec_o[CW + 2*C*k + C +: C] = vy[k];
    end
  end

  // Item retirement: invisible edges and a close before any visible edge leave right away.
  logic skip, fin_done, done;
  assign skip     = (it_mode_q == vrcc_pkg::MODE_CLOSE) ? !started_q : !it_vis_q;
  assign fin_done = item_valid_q && (phase_q == PH_FIN) && ((n == '0) || !full_i);
  assign done     = fin_done || (item_valid_q && (phase_q == PH_SQ1) && skip);
  assign push_o   = fin_done && (n != '0);
  assign in_ready_o = !item_valid_q || done;

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  // Sequencer, configuration and polygon state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SQ1;
      item_valid_q <= 1'b0;
      started_q    <= 1'b0;
      fa_x_q       <= '0;
      fa_y_q       <= '0;
      fb_x_q       <= '0;
      fb_y_q       <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      bnd_l_q      <= '0;
      bnd_r_q      <= '0;
      bnd_t_q      <= '0;
      bnd_b_q      <= '0;
      near_q       <= vrcc_pkg::NEAR_RESET;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          vrcc_pkg::CFG_LEFT:   bnd_l_q <= cfg_data_i[C-1:0];
          vrcc_pkg::CFG_RIGHT:  bnd_r_q <= cfg_data_i[C-1:0];
          vrcc_pkg::CFG_TOP:    bnd_t_q <= cfg_data_i[C-1:0];
          vrcc_pkg::CFG_BOTTOM: bnd_b_q <= cfg_data_i[C-1:0];
          vrcc_pkg::CFG_NEAR:   near_q  <= cfg_data_i[NB-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        item_valid_q <= 1'b1;
        phase_q      <= PH_SQ1;
      end else if (done) begin
        item_valid_q <= 1'b0;
        phase_q      <= PH_SQ1;
      end else if (item_valid_q) begin
        unique case (phase_q)
          PH_SQ1:  phase_q <= PH_SQ2;
          PH_SQ2:  phase_q <= PH_FIN;
          PH_FIN:  phase_q <= PH_FIN;
          default: phase_q <= PH_SQ1;
        endcase
      end

      if (fin_done) begin
        if (it_mode_q == vrcc_pkg::MODE_CLOSE) begin
          started_q <= 1'b0;
        end else if (!started_q) begin
          started_q <= 1'b1;
          fa_x_q    <= it_ax_q;
          fa_y_q    <= it_ay_q;
          fb_x_q    <= it_bx_q;
          fb_y_q    <= it_by_q;
        end
        if (n != '0) begin
          prev_x_q <= vx[n_last[IW-1:0]];
          prev_y_q <= vy[n_last[IW-1:0]];
        end
      end
    end
  end

  // Held item and phase datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      it_mode_q <= mode_i;
      it_vis_q  <= visible_i;
      it_ax_q   <= end_a_x_i;
      it_ay_q   <= end_a_y_i;
      it_bx_q   <= end_b_x_i;
      it_by_q   <= end_b_y_i;
    end
    if (phase_q != PH_FIN) begin
      sq_x_q <= sq_x_d;
      sq_y_q <= sq_y_d;
      big_q  <= big_d;
    end
    if (phase_q == PH_SQ2) begin
      coin1_q  <= coin_now;
      rs_q     <= rs_d;
      ns_q     <= ns_d;
      upper_q  <= (up_sum < up_span);
      lefter_q <= (lf_sum < lf_span);
      diff_q   <= (prev_x_q != ja_x) && (prev_y_q != ja_y);
    end
  end

  `VRCC_ASSERT_NEXT(a_front_sq2_one_cycle, item_valid_q && (phase_q == PH_SQ2),
                    (phase_q == PH_FIN) || (phase_q == PH_SQ1), "second phase lasted too long")
  `VRCC_ASSERT_IMP(a_front_push_has_item, push_o, item_valid_q && !skip,
                   "record pushed for an item that emits nothing")

endmodule

// ----- design/vrcc_back.sv -----
// Back part: walks each queued record, one vertex word per cycle when not stalled.
`include "assert_macros.svh"

module vrcc_back #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned REC_W      = 195
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [REC_W-1:0]             rec_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o,
  output logic                         last_of_run_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned NV = vrcc_pkg::MAX_VERTS;
  localparam int unsigned CW = vrcc_pkg::CNT_W;
  localparam int unsigned IW = vrcc_pkg::VIDX_W;

  logic                out_valid_q;
  logic signed [C-1:0] out_x_q, out_y_q;
  logic                out_last_q;
  logic [IW-1:0]       idx_q;

  // Unpack the head record.
  logic signed [C-1:0] hx [NV];
  logic signed [C-1:0] hy [NV];
  logic [CW-1:0]       hn;
  always_comb begin
    hn = rec_i[CW-1:0];
    for (int k = 0; k < NV; k++) begin
      hx[k] = rec_i[CW + 2*C*k +: C];
      hy[k] = rec_i[CW + 2*C*k + C +: C];
    end
  end

  // The output register takes a new word when empty or when its word is taken.
  logic load, take, at_last;
  assign load    = !out_valid_q || out_ready_i;
  assign take    = load && !empty_i;
  assign at_last = (CW'(idx_q) == hn - 1'b1);
  assign pop_o   = take && at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      out_valid_q <= !empty_i;
      if (take) begin
        idx_q <= at_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_x_q    <= hx[idx_q];
      out_y_q    <= hy[idx_q];
      out_last_q <= at_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign last_of_run_o = out_last_q;

  `VRCC_ASSERT_IMP(a_back_record_nonempty, !empty_i, (hn != '0) && (hn <= CW'(NV)),
                   "queued record with no vertices or too many")
  `VRCC_ASSERT_IMP(a_back_index_in_record, !empty_i, CW'(idx_q) < hn,
                   "vertex index beyond its record")

endmodule

// ----- design/voronoi_region_clip_closer_core.sv -----
// Top level of the clipped cell outline builder: front part, record queue and back part.
//
// Use: configure the clipping rectangle and the coincidence limit through the plain
// write port while the block is idle, then stream one cell's ordered edges on the input
// channel and finish the cell with a close item. Each vertex of the clipped polygon
// leaves as one word on the output channel; last_of_run marks the final word that an
// input caused. Invisible edges and a close before any visible edge produce no word.
// An item's first word passes the front's SQ1, SQ2 and FIN phases, the record queue
// and the back part's output register. The front part runs its two coincidence tests
// one after the other on a shared distance unit and takes the next item as the held
// one retires; an invisible edge or a close before any visible edge retires in the
// first phase. The back part hands out one word per cycle while the receiver is ready.
// A two-entry record queue lets the front keep taking items while the receiver stalls;
// when it fills, input ready drops until the back part frees an entry.
// Reset clears the polygon state, the rectangle to zero and the limit to two; no word
// is pending after reset.
module voronoi_region_clip_closer_core #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_we_i,
  input  logic [vrcc_pkg::CFG_IDX_W-1:0]                cfg_index_i,
  input  logic [((COORD_BITS > vrcc_pkg::NEAR_BITS) ?
                 COORD_BITS : vrcc_pkg::NEAR_BITS)-1:0] cfg_data_i,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic                                          mode_i,
  input  logic                                          visible_i,
  input  logic signed [COORD_BITS-1:0]                  end_a_x_i,
  input  logic signed [COORD_BITS-1:0]                  end_a_y_i,
  input  logic signed [COORD_BITS-1:0]                  end_b_x_i,
  input  logic signed [COORD_BITS-1:0]                  end_b_y_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic signed [COORD_BITS-1:0]                  out_x_o,
  output logic signed [COORD_BITS-1:0]                  out_y_o,
  output logic                                          last_of_run_o
);

  localparam int unsigned CFG_W = (COORD_BITS > vrcc_pkg::NEAR_BITS) ?
                                  COORD_BITS : vrcc_pkg::NEAR_BITS;
  localparam int unsigned REC_W = vrcc_pkg::MAX_VERTS * 2 * COORD_BITS + vrcc_pkg::CNT_W;

  logic             q_push, q_full, q_pop, q_empty;
  logic [REC_W-1:0] q_wdata, q_rdata;

  // Front part: item intake, tests and record assembly.
  vrcc_front #(
    .COORD_BITS (COORD_BITS),
    .CFG_W      (CFG_W),
    .REC_W      (REC_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .visible_i   (visible_i),
    .end_a_x_i   (end_a_x_i),
    .end_a_y_i   (end_a_y_i),
    .end_b_x_i   (end_b_x_i),
    .end_b_y_i   (end_b_y_i),
    .push_o      (q_push),
    .rec_o       (q_wdata),
    .full_i      (q_full)
  );

  // Record queue between the two parts.
  vrcc_queue #(
    .WIDTH (REC_W),
    .DEPTH (vrcc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // Back part: vertex output register.
  vrcc_back #(
    .COORD_BITS (COORD_BITS),
    .REC_W      (REC_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_i         (q_rdata),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
